[src/s2cd_pkg.sv]
// Constants, tables and helper functions for the seconds-to-calendar-date pipeline.
package s2cd_pkg;

    // Stream field widths.
    localparam int SEC_W      = 32;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 12;
    localparam int OUT_W      = DAY_W + MONTH_W + YEAR_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Day count since the epoch fits 16 bits (at most 49710).
    localparam int DAYS_W = 16;
    // Year offset from the epoch year, searched one bit per stage.
    localparam int YIDX_W = 8;
    localparam int YEAR_TAB_N = 1 << YIDX_W;
    // Day within the year, below 366.
    localparam int DOY_W = 9;

    // Division by 86400 = 128 * 675: drop 7 bits, then multiply by a
    // rounded-up reciprocal of 675 and keep the bits above QUO_LSB.
    // The rounding error times the largest dividend stays below 2^QUO_LSB,
    // so the quotient is exact over the whole input range.
    localparam int SEC_SHIFT  = 7;
    localparam int DIVIDEND_W = SEC_W - SEC_SHIFT;
    localparam int MULT_W     = 26;
    localparam logic [MULT_W-1:0] DIV_MULT = 26'd50903317;
    localparam int QUO_LSB    = 35;
    localparam int PROD_W     = DIVIDEND_W + MULT_W;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd2000;
    // Last year offset reachable by the input range (year 2136).
    localparam int YEAR_LAST_IDX = 136;
    // Offset of the century year 2100, the only non-leap multiple of four in range.
    localparam logic [YIDX_W-1:0] YIDX_2100 = 8'd100;

    localparam int MONTHS = 12;
    localparam int FEB    = 1;

    typedef logic [DAYS_W-1:0] t_year_tab [YEAR_TAB_N];
    typedef logic [DOY_W-1:0]  t_month_tab [MONTHS];

    // Days from the epoch to 1 January of each year offset. Offsets past the
    // last reachable year hold all ones, so a search never selects them.
    function automatic t_year_tab calc_year_start();
        t_year_tab tab;
        int acc;
        int c4;
        int c100;
        int c400;
        acc  = 0;
        c4   = 0;
        c100 = 0;
        c400 = 0;
        for (int i = 0; i < YEAR_TAB_N; i++) begin
            tab[i] = (i <= YEAR_LAST_IDX) ? DAYS_W'(acc) : '1;
            if (c4 == 0 && (c100 != 0 || c400 == 0)) begin
                acc = acc + 366;
            end else begin
                acc = acc + 365;
            end
            c4   = (c4 == 3) ? 0 : c4 + 1;
            c100 = (c100 == 99) ? 0 : c100 + 1;
            c400 = (c400 == 399) ? 0 : c400 + 1;
        end
        return tab;
    endfunction

    localparam t_year_tab YEAR_START = calc_year_start();

    // Day of year on which each month starts in a common year.
    localparam t_month_tab MONTH_START = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Month start with the leap day added after February.
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mon,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        base = MONTH_START[mon];
        if (leap && mon > MONTH_W'(FEB)) begin
            base = base + DOY_W'(1);
        end
        return base;
    endfunction

endpackage

[src/seconds_to_calendar_date.sv]
// Seconds since 1 January 2000 to Gregorian day, month and full year.
//
// The input stream carries one request per item: a 32-bit unsigned count of
// seconds since midnight, 1 January 2000. For every request the output stream
// gives exactly one date: day of month (1..31), month (1..12) and year.
// The time of day is dropped.
//
// The block is a 12-stage pipeline: one multiplier stage for the division by
// seconds per day, eight stages of a bitwise search over a table of year
// starts, one stage that forms the day of year, one that finds the month and
// one output stage. One request is accepted every cycle while the output
// is taken.
//
// All stages advance together. When the receiver holds i_m_axis_tready low
// with a result waiting, the whole pipeline freezes and o_s_axis_tready goes
// low; nothing is dropped or repeated. Reset clears the stage valid bits
// only, so the pipeline comes out of reset empty and ready.
module seconds_to_calendar_date (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] seconds
    input  logic [s2cd_pkg::SEC_W-1:0]      i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [4:0] day_of_month, [8:5] month_number, [20:9] year_number, [23:21] zero
    output logic [s2cd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import s2cd_pkg::*;

    localparam int NSTG   = YIDX_W + 4;
    localparam int ST_OUT = NSTG - 1;

    logic [NSTG-1:0] r_valid;
    logic            w_adv;

    // Stage registers.
    logic [PROD_W-1:0]  r_prod;
    logic [DAYS_W-1:0]  r_days [1:YIDX_W];
    logic [YIDX_W-1:0]  r_idx  [1:YIDX_W];
    logic [DAYS_W-1:0]  w_days [0:YIDX_W];
    logic [YIDX_W-1:0]  w_idx  [0:YIDX_W];
    logic [YIDX_W-1:0]  r_yidx_d;
    logic [DOY_W-1:0]   r_doy_d;
    logic               r_leap_d;
    logic [YIDX_W-1:0]  r_yidx_m;
    logic [DOY_W-1:0]   r_doy_m;
    logic               r_leap_m;
    logic [MONTH_W-1:0] r_mon_m;
    logic [DAY_W-1:0]   r_day_o;
    logic [MONTH_W-1:0] r_mon_o;
    logic [YEAR_W-1:0]  r_year_o;

    logic [PROD_W-1:0]  n_prod;
    logic [DOY_W-1:0]   n_doy;
    logic               n_leap;
    logic [MONTH_W-1:0] n_mon;
    logic [DAY_W-1:0]   n_day;

    // The pipeline moves whenever the output stage is empty or being taken.
    assign w_adv           = !r_valid[ST_OUT] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_valid[ST_OUT];
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, r_year_o, r_mon_o, r_day_o};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    // Seconds to days: reciprocal multiply of the seconds with the low 7 bits dropped.
    assign n_prod = {{MULT_W{1'b0}}, i_s_axis_tdata[SEC_W-1:SEC_SHIFT]}
                  * {{DIVIDEND_W{1'b0}}, DIV_MULT};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prod <= n_prod;
        end
    end

    assign w_days[0] = r_prod[QUO_LSB +: DAYS_W];
    assign w_idx[0]  = '0;

    // Year search: each stage decides one bit of the year offset, from the top.
    for (genvar k = 1; k <= YIDX_W; k++) begin : g_search
        logic [YIDX_W-1:0] w_cand;
        assign w_cand    = w_idx[k-1] | (YIDX_W'(1) << (YIDX_W - k));
        assign w_days[k] = r_days[k];
        assign w_idx[k]  = r_idx[k];

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_days[k] <= w_days[k-1];
                r_idx[k]  <= (YEAR_START[w_cand] <= w_days[k-1]) ? w_cand : w_idx[k-1];
            end
        end
    end

    // Day of year and leap flag. Within 2000..2136 every fourth year is a
    // leap year except the century year 2100.
    assign n_doy  = DOY_W'(w_days[YIDX_W] - YEAR_START[w_idx[YIDX_W]]);
    assign n_leap = (w_idx[YIDX_W][1:0] == 2'b00) && (w_idx[YIDX_W] != YIDX_2100);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_yidx_d <= w_idx[YIDX_W];
            r_doy_d  <= n_doy;
            r_leap_d <= n_leap;
        end
    end

    // Month: count the month starts at or below the day of year.
    always_comb begin
        n_mon = '0;
        for (int m = 1; m < MONTHS; m++) begin
            if (r_doy_d >= month_start(MONTH_W'(m), r_leap_d)) begin
                n_mon = n_mon + MONTH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_yidx_m <= r_yidx_d;
            r_doy_m  <= r_doy_d;
            r_leap_m <= r_leap_d;
            r_mon_m  <= n_mon;
        end
    end

    // Day within the month, 1-based, and final output register.
    assign n_day = DAY_W'(r_doy_m - month_start(r_mon_m, r_leap_m) + DOY_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_day_o  <= n_day;
            r_mon_o  <= r_mon_m + MONTH_W'(1);
            r_year_o <= EPOCH_YEAR + YEAR_W'(r_yidx_m);
        end
    end

endmodule
